@@ src/gcd_pkg.sv @@
package gcd_pkg;

    localparam int CORDIC_STEPS = 30;

    // CORDIC working word: Q30 with headroom for gain growth and angle overshoot
    typedef logic signed [32:0] cordic_t;

    localparam cordic_t CORDIC_GAIN = 33'sd652032874;
    localparam cordic_t ONE_Q30     = 33'sd1073741824;

    // arctangent of 2^-i as a binary angle, full turn = 2^32
    localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
    };

endpackage

@@ src/gcd_sincos.sv @@
module gcd_sincos (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        phase,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30
);

    gcd_pkg::cordic_t x_reg [gcd_pkg::CORDIC_STEPS+1];
    gcd_pkg::cordic_t y_reg [gcd_pkg::CORDIC_STEPS+1];
    gcd_pkg::cordic_t z_reg [gcd_pkg::CORDIC_STEPS+1];
    logic [1:0]       quad_reg [gcd_pkg::CORDIC_STEPS+1];

    gcd_pkg::cordic_t  x_clamp;
    gcd_pkg::cordic_t  y_clamp;
    logic signed [31:0] xc;
    logic signed [31:0] yc;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;

    // rotate by the angle inside the quadrant, fold the quadrant in at the end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= gcd_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({3'b000, phase[29:0]});
            quad_reg[0] <= phase[31:30];
        end
    end

    for (genvar i = 0; i < gcd_pkg::CORDIC_STEPS; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][32])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed({3'b000, gcd_pkg::ATAN_TURN[i]});
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed({3'b000, gcd_pkg::ATAN_TURN[i]});
                end
                quad_reg[i+1] <= quad_reg[i];
            end
        end
    end

    always_comb
    begin
        if (x_reg[gcd_pkg::CORDIC_STEPS] > gcd_pkg::ONE_Q30)
            x_clamp = gcd_pkg::ONE_Q30;
        else if (x_reg[gcd_pkg::CORDIC_STEPS] < -gcd_pkg::ONE_Q30)
            x_clamp = -gcd_pkg::ONE_Q30;
        else
            x_clamp = x_reg[gcd_pkg::CORDIC_STEPS];

        if (y_reg[gcd_pkg::CORDIC_STEPS] > gcd_pkg::ONE_Q30)
            y_clamp = gcd_pkg::ONE_Q30;
        else if (y_reg[gcd_pkg::CORDIC_STEPS] < -gcd_pkg::ONE_Q30)
            y_clamp = -gcd_pkg::ONE_Q30;
        else
            y_clamp = y_reg[gcd_pkg::CORDIC_STEPS];

        xc = x_clamp[31:0];
        yc = y_clamp[31:0];

        case (quad_reg[gcd_pkg::CORDIC_STEPS])
            2'd0:
            begin
                cos_next = xc;
                sin_next = yc;
            end
            2'd1:
            begin
                cos_next = -yc;
                sin_next = xc;
            end
            2'd2:
            begin
                cos_next = -xc;
                sin_next = -yc;
            end
            default:
            begin
                cos_next = yc;
                sin_next = -xc;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule

@@ src/great_circle_distance_core.sv @@
// Haversine great-circle distance between two points, one point pair per beat.
// Input channel (in_valid/in_ready): lat_a, lng_a, lat_b, lng_b in degrees,
// two's complement with 24 fractional bits. Output channel (out_valid/out_ready):
// distance in meters with 8 fractional bits, one result per input beat, in order.
// The APB port holds one register at address 0: sphere_radius in whole meters
// (24 bits). Write it only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. The depth is
// set by the four parallel 30-step sine/cosine CORDIC pipelines, the 31-step
// square-root pipelines and the 30-step arctangent CORDIC pipeline, each step
// one register stage.
// A stalled receiver first fills the output register and a one-entry skid
// register; the pipeline then freezes in place and in_ready drops until the
// skid register drains. Nothing is dropped or repeated.
// Reset clears all valid bits and loads sphere_radius with 6371000.
module great_circle_distance_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] lat_a,
    input  logic signed [32:0] lng_a,
    input  logic signed [31:0] lat_b,
    input  logic signed [32:0] lng_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [33:0]        distance
);

    localparam int PIPE_DEPTH = 102;

    localparam logic               REG_RADIUS   = 1'b0;
    localparam logic [23:0]        RADIUS_RESET = 24'd6371000;
    localparam logic signed [34:0] DEG_TURN     = 35'sd6039797760;
    localparam logic signed [34:0] DEG_TURN2    = 35'sd12079595520;
    localparam logic [37:0]        ROUND_BIAS   = 38'd22;
    // ceil(2^44 / 45): exact floor division by 45 for dividends below 2^38
    localparam logic [38:0]        DIV45_MUL    = 39'd390937467654;
    localparam logic signed [63:0] ONE_Q60      = 64'sh1000_0000_0000_0000;
    localparam logic [30:0]        ONE_Q30_U    = 31'h4000_0000;
    localparam logic [30:0]        PI_Q29       = 31'd1686629713;

    typedef struct packed {
        logic [34:0] rem;
        logic [30:0] root;
    } sq_t;

    function automatic logic [32:0] wrap_turn(input logic signed [34:0] d);
        logic signed [34:0] r;
        if (d >= DEG_TURN)
            r = d - DEG_TURN;
        else if (d >= 0)
            r = d;
        else if (d >= -DEG_TURN)
            r = d + DEG_TURN;
        else
            r = d + DEG_TURN2;
        return r[32:0];
    endfunction

    function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] pair);
        logic [34:0] acc;
        logic [34:0] trial;
        sq_t         r;
        acc   = {s.rem[32:0], pair};
        trial = {2'b00, s.root, 2'b01};
        if (acc >= trial)
        begin
            r.rem  = acc - trial;
            r.root = {s.root[29:0], 1'b1};
        end
        else
        begin
            r.rem  = acc;
            r.root = {s.root[29:0], 1'b0};
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [23:0] radius_reg;
    logic        cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (cfg_wr && paddr[2] == REG_RADIUS)
            radius_reg <= pwdata[23:0];
    end

    always_comb
    begin
        if (paddr[2] == REG_RADIUS)
            prdata = {8'd0, radius_reg};
        else
            prdata = '0;
    end

    // ---------------- flow control ----------------
    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  skid_vld_reg;
    logic                  skid_vld_next;
    logic                  out_vld_reg;
    logic                  out_vld_next;

    assign adv      = !skid_vld_reg;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
    end

    // ---------------- angle reduction ----------------
    logic signed [32:0] dlat;
    logic signed [33:0] dlng;
    logic [32:0]        r_next [4];
    logic [37:0]        p_reg  [4];

    assign dlat = {lat_b[31], lat_b} - {lat_a[31], lat_a};
    assign dlng = {lng_b[32], lng_b} - {lng_a[32], lng_a};

    always_comb
    begin
        r_next[0] = wrap_turn({{3{lat_a[31]}}, lat_a});
        r_next[1] = wrap_turn({{3{lat_b[31]}}, lat_b});
        r_next[2] = wrap_turn({{2{dlat[32]}}, dlat});
        r_next[3] = wrap_turn({dlng[33], dlng});
    end

    // full-angle dividend floor((r*256+180)/8), half-angle floor((r*128+180)/8)
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0] <= {r_next[0], 5'd0} + ROUND_BIAS;
            p_reg[1] <= {r_next[1], 5'd0} + ROUND_BIAS;
            p_reg[2] <= {1'b0, r_next[2], 4'd0} + ROUND_BIAS;
            p_reg[3] <= {1'b0, r_next[3], 4'd0} + ROUND_BIAS;
        end
    end

    // ---------------- divide by 45 into a binary angle ----------------
    logic [38:0] pp00_reg [4];
    logic [37:0] pp01_reg [4];
    logic [38:0] pp10_reg [4];
    logic [37:0] pp11_reg [4];
    logic [77:0] quo_sum  [4];
    logic [31:0] phase_reg [4];

    for (genvar k = 0; k < 4; k++)
    begin : g_phase
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pp00_reg[k] <= p_reg[k][18:0]  * DIV45_MUL[19:0];
                pp01_reg[k] <= p_reg[k][18:0]  * DIV45_MUL[38:20];
                pp10_reg[k] <= p_reg[k][37:19] * DIV45_MUL[19:0];
                pp11_reg[k] <= p_reg[k][37:19] * DIV45_MUL[38:20];
            end
        end

        assign quo_sum[k] = 78'(pp00_reg[k])
                          + (78'(pp01_reg[k]) << 20)
                          + (78'(pp10_reg[k]) << 19)
                          + (78'(pp11_reg[k]) << 39);

        always_ff @(posedge clk)
        begin
            if (adv)
                phase_reg[k] <= quo_sum[k][75:44];
        end
    end

    // ---------------- sine and cosine ----------------
    logic signed [31:0] cos_a;
    logic signed [31:0] cos_b;
    logic signed [31:0] sin_lat;
    logic signed [31:0] sin_lon;

    gcd_sincos u_sc_lat_a (
        .clk     (clk),
        .en      (adv),
        .phase   (phase_reg[0]),
        .cos_q30 (cos_a),
        .sin_q30 ()
    );

    gcd_sincos u_sc_lat_b (
        .clk     (clk),
        .en      (adv),
        .phase   (phase_reg[1]),
        .cos_q30 (cos_b),
        .sin_q30 ()
    );

    gcd_sincos u_sc_dlat (
        .clk     (clk),
        .en      (adv),
        .phase   (phase_reg[2]),
        .cos_q30 (),
        .sin_q30 (sin_lat)
    );

    gcd_sincos u_sc_dlng (
        .clk     (clk),
        .en      (adv),
        .phase   (phase_reg[3]),
        .cos_q30 (),
        .sin_q30 (sin_lon)
    );

    // ---------------- haversine term ----------------
    logic signed [63:0] cc_reg;
    logic signed [63:0] sl2_reg;
    logic signed [31:0] slon1_reg;
    logic signed [63:0] t_full;
    logic signed [63:0] tu_reg;
    logic signed [63:0] sl2b_reg;
    logic signed [31:0] slon2_reg;
    logic signed [63:0] u_full;
    logic signed [63:0] ul_reg;
    logic signed [63:0] sl2c_reg;
    logic signed [63:0] hav_sum;
    logic [60:0]        a_clamp;

    assign t_full  = cc_reg >>> 30;
    assign u_full  = tu_reg >>> 30;
    assign hav_sum = sl2c_reg + ul_reg;

    always_comb
    begin
        if (hav_sum < 0)
            a_clamp = '0;
        else if (hav_sum > ONE_Q60)
            a_clamp = ONE_Q60[60:0];
        else
            a_clamp = hav_sum[60:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cc_reg    <= cos_a * cos_b;
            sl2_reg   <= sin_lat * sin_lat;
            slon1_reg <= sin_lon;

            tu_reg    <= $signed(t_full[31:0]) * slon1_reg;
            sl2b_reg  <= sl2_reg;
            slon2_reg <= slon1_reg;

            ul_reg    <= $signed(u_full[31:0]) * slon2_reg;
            sl2c_reg  <= sl2b_reg;
        end
    end

    // ---------------- square roots, two bits of radicand per stage ----------------
    sq_t         sqa_reg  [32];
    sq_t         sqb_reg  [32];
    logic [61:0] rada_reg [32];
    logic [61:0] radb_reg [32];
    logic [60:0] b_val;

    assign b_val = ONE_Q60[60:0] - a_clamp;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqa_reg[0]  <= '0;
            sqb_reg[0]  <= '0;
            rada_reg[0] <= {1'b0, a_clamp};
            radb_reg[0] <= {1'b0, b_val};
        end
    end

    for (genvar j = 0; j < 31; j++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sqa_reg[j+1]  <= sqrt_step(sqa_reg[j], rada_reg[j][61-2*j -: 2]);
                sqb_reg[j+1]  <= sqrt_step(sqb_reg[j], radb_reg[j][61-2*j -: 2]);
                rada_reg[j+1] <= rada_reg[j];
                radb_reg[j+1] <= radb_reg[j];
            end
        end
    end

    // ---------------- arctangent by vectoring CORDIC ----------------
    logic signed [33:0]  at_x_cur [gcd_pkg::CORDIC_STEPS];
    logic signed [33:0]  at_y_cur [gcd_pkg::CORDIC_STEPS];
    gcd_pkg::cordic_t    at_z_cur [gcd_pkg::CORDIC_STEPS];
    logic signed [33:0]  at_x_reg [gcd_pkg::CORDIC_STEPS];
    logic signed [33:0]  at_y_reg [gcd_pkg::CORDIC_STEPS];
    gcd_pkg::cordic_t    at_z_reg [gcd_pkg::CORDIC_STEPS];

    for (genvar i = 0; i < gcd_pkg::CORDIC_STEPS; i++)
    begin : g_atan
        if (i == 0)
        begin : g_first
            assign at_x_cur[i] = $signed({3'b000, sqb_reg[31].root});
            assign at_y_cur[i] = $signed({3'b000, sqa_reg[31].root});
            assign at_z_cur[i] = '0;
        end
        else
        begin : g_rest
            assign at_x_cur[i] = at_x_reg[i-1];
            assign at_y_cur[i] = at_y_reg[i-1];
            assign at_z_cur[i] = at_z_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (at_y_cur[i] > 0)
                begin
                    at_x_reg[i] <= at_x_cur[i] + (at_y_cur[i] >>> i);
                    at_y_reg[i] <= at_y_cur[i] - (at_x_cur[i] >>> i);
                    at_z_reg[i] <= at_z_cur[i] + $signed({3'b000, gcd_pkg::ATAN_TURN[i]});
                end
                else
                begin
                    at_x_reg[i] <= at_x_cur[i] - (at_y_cur[i] >>> i);
                    at_y_reg[i] <= at_y_cur[i] + (at_x_cur[i] >>> i);
                    at_z_reg[i] <= at_z_cur[i] - $signed({3'b000, gcd_pkg::ATAN_TURN[i]});
                end
            end
        end
    end

    // ---------------- scale by pi and radius ----------------
    gcd_pkg::cordic_t z_fin;
    logic [30:0]      z_clamp;
    logic [61:0]      m_reg;
    logic [64:0]      w_reg;
    logic [65:0]      w_round;
    logic [33:0]      dist_next;

    assign z_fin = at_z_reg[gcd_pkg::CORDIC_STEPS-1];

    always_comb
    begin
        if (z_fin < 0)
            z_clamp = '0;
        else if (z_fin > gcd_pkg::ONE_Q30)
            z_clamp = ONE_Q30_U;
        else
            z_clamp = z_fin[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg <= z_clamp * PI_Q29;
            w_reg <= m_reg[61:21] * radius_reg;
        end
    end

    assign w_round   = 66'(w_reg) + 66'(32'h2000_0000);
    assign dist_next = w_round[63:30];

    // ---------------- output register and skid ----------------
    logic        pipe_vld;
    logic        out_free;
    logic        load_out_pipe;
    logic        load_out_skid;
    logic        load_skid;
    logic [33:0] out_data_reg;
    logic [33:0] skid_data_reg;

    assign pipe_vld = adv && vld_reg[PIPE_DEPTH-1];
    assign out_free = !out_vld_reg || out_ready;

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        load_out_pipe = 1'b0;
        load_out_skid = 1'b0;
        load_skid     = 1'b0;
        if (skid_vld_reg)
        begin
            if (out_free)
            begin
                load_out_skid = 1'b1;
                skid_vld_next = 1'b0;
                out_vld_next  = 1'b1;
            end
        end
        else if (pipe_vld)
        begin
            if (out_free)
            begin
                load_out_pipe = 1'b1;
                out_vld_next  = 1'b1;
            end
            else
            begin
                // hold the beat until the receiver drains the output register
                load_skid     = 1'b1;
                skid_vld_next = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_skid)
            out_data_reg <= skid_data_reg;
        else if (load_out_pipe)
            out_data_reg <= dist_next;
        if (load_skid)
            skid_data_reg <= dist_next;
    end

    assign out_valid = out_vld_reg;
    assign distance  = out_data_reg;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid register holds a beat while the output register is empty");

    a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !out_ready))
        else $error("skid register filled while the output register was free");

endmodule
